// ----- hdl/alarm_indicator_led_breath_blink_unit_assert.svh -----
// Assertion macros used by the checker file of the alarm indicator unit.
`ifndef ALARM_INDICATOR_LED_BREATH_BLINK_UNIT_ASSERT_SVH
`define ALARM_INDICATOR_LED_BREATH_BLINK_UNIT_ASSERT_SVH

// Same-cycle implication under reset.
`define AILB_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ailb same-cycle check failed");

// Next-cycle implication under reset.
`define AILB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ailb next-cycle check failed");

`endif

// ----- hdl/ailb_pkg.sv -----
// Package: types, codes and constants of the alarm indicator LED unit.
package ailb_pkg;

    // event codes
    localparam logic [1:0] MODE_TICK   = 2'd0;
    localparam logic [1:0] MODE_ALARM  = 2'd1;
    localparam logic [1:0] MODE_LOWBAT = 2'd2;

    // LED modes
    localparam logic [1:0] LED_OFF    = 2'd0;
    localparam logic [1:0] LED_BREATH = 2'd1;
    localparam logic [1:0] LED_FAST   = 2'd2;
    localparam logic [1:0] LED_SOLID  = 2'd3;

    // alarm states
    localparam logic [2:0] AL_IDLE      = 3'd0;
    localparam logic [2:0] AL_CONFIRM   = 3'd1;
    localparam logic [2:0] AL_PENDING   = 3'd2;
    localparam logic [2:0] AL_CALLING   = 3'd3;
    localparam logic [2:0] AL_STOPPING  = 3'd4;
    localparam logic [2:0] AL_CONNECTED = 3'd5;
    localparam logic [2:0] AL_FAILED    = 3'd6;

    // configuration register indexes
    localparam logic [1:0] CFG_TICK_MS    = 2'd0;
    localparam logic [1:0] CFG_BREATH_CYC = 2'd1;
    localparam logic [1:0] CFG_FAST_HALF  = 2'd2;
    localparam logic [1:0] CFG_PWM_PERIOD = 2'd3;

    // configuration reset values
    localparam logic [9:0]  TICK_MS_RST    = 10'd20;
    localparam logic [15:0] BREATH_CYC_RST = 16'd2000;
    localparam logic [15:0] FAST_HALF_RST  = 16'd200;
    localparam logic [15:0] PWM_PERIOD_RST = 16'd1000;

    // shared divider sizing
    localparam int DVD_W  = 32;
    localparam int DSR_W  = 16;
    localparam int STEP_W = 6;
    localparam logic [STEP_W-1:0] MOD_STEPS = 6'd17;
    localparam logic [STEP_W-1:0] DIV_STEPS = 6'd32;

    typedef struct packed {
        logic [1:0] mode;
        logic [2:0] alarm_state;
    } in_item_t;

    typedef struct packed {
        logic [15:0] led_duty;
        logic [1:0]  led_mode_now;
        logic        buzzer_on;
        logic        vibration_on;
    } out_item_t;

    typedef struct packed {
        logic              start;
        logic [STEP_W-1:0] steps;
        logic [DVD_W-1:0]  dividend;
        logic [DSR_W-1:0]  divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [DVD_W-1:0] quot;
        logic [DSR_W-1:0] rem;
    } div_rsp_t;

endpackage

// ----- hdl/ailb_div.sv -----
// Shared restoring divider: one compare-subtract step per cycle.
module ailb_div
(
    input  logic              clk,
    input  logic              rst_n,
    input  ailb_pkg::div_req_t req,
    output ailb_pkg::div_rsp_t rsp
);

    logic [ailb_pkg::STEP_W-1:0] cnt_reg;
    logic                        done_reg;
    logic [ailb_pkg::DVD_W-1:0]  dvd_reg;
    logic [ailb_pkg::DSR_W-1:0]  dsr_reg;
    logic [ailb_pkg::DSR_W-1:0]  rem_reg;

    logic [ailb_pkg::DSR_W:0]    rem_sh;
    logic [ailb_pkg::DSR_W:0]    rem_diff;
    logic                        ge;

    // one restoring step: shift in the next dividend bit, subtract if it fits
    always_comb
    begin
        rem_sh   = {rem_reg, dvd_reg[ailb_pkg::DVD_W-1]};
        ge       = rem_sh >= {1'b0, dsr_reg};
        rem_diff = rem_sh - {1'b0, dsr_reg};
    end

    // step counter and done pulse
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                cnt_reg <= req.steps;
            end
            else if (cnt_reg != '0)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == ailb_pkg::STEP_W'(1))
                begin
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            dvd_reg <= req.dividend;
            dsr_reg <= req.divisor;
            rem_reg <= '0;
        end
        else if (cnt_reg != '0)
        begin
            dvd_reg <= {dvd_reg[ailb_pkg::DVD_W-2:0], ge};
            rem_reg <= ge ? rem_diff[ailb_pkg::DSR_W-1:0] : rem_sh[ailb_pkg::DSR_W-1:0];
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quot = dvd_reg;
    assign rsp.rem  = rem_reg;

endmodule

// ----- hdl/alarm_indicator_led_breath_blink_unit.sv -----
// Top level of the alarm indicator LED, buzzer and vibration driver.
// One event is taken at a time. A tick in breathing mode with a cycle of
// two or more runs the phase wrap on the shared divider (17 steps), the
// ramp multiply and the duty division on the divider (32 steps), then
// hands the result to the output register and returns to idle, where the
// unit can take the next event. Every other event goes straight to the
// hand-over. The shared divider does one compare-subtract per cycle; a
// result still held by a stalled receiver holds the hand-over back.
// Each event yields exactly one result beat showing the state after it; the
// output register lets the result wait while the next event is taken.
module alarm_indicator_led_breath_blink_unit
#(
    parameter int DUTY_BITS = 16
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  ailb_pkg::in_item_t  in_data,
    output logic                out_valid,
    input  logic                out_stall,
    output ailb_pkg::out_item_t out_data,
    input  logic                cfg_we,
    input  logic [1:0]          cfg_index,
    input  logic [15:0]         cfg_data
);

    // duty saturation limit from the PWM counter width
    localparam logic [15:0] DutyLim = (DUTY_BITS >= 16) ? 16'hFFFF :
                                      16'((64'd1 << DUTY_BITS) - 64'd1);

    typedef enum logic [4:0]
    {
        S_IDLE = 5'b00001,
        S_MOD  = 5'b00010,
        S_MUL  = 5'b00100,
        S_DIV  = 5'b01000,
        S_DONE = 5'b10000
    } state_t;

    function automatic logic [15:0] sat_duty(input logic [15:0] d);
        sat_duty = (d > DutyLim) ? DutyLim : d;
    endfunction

    state_t state_reg, state_next;

    logic [9:0]  tick_ms_reg;
    logic [15:0] breath_cyc_reg;
    logic [15:0] fast_half_reg;
    logic [15:0] pwm_period_reg;

    logic [1:0]  led_mode_reg, led_mode_next;
    logic [16:0] elapsed_reg, elapsed_next;
    logic        phase_reg, phase_next;
    logic [15:0] duty_reg, duty_next;
    logic        buzzer_reg, buzzer_next;
    logic        vibration_reg, vibration_next;
    logic [15:0] ramp_reg, ramp_next;

    logic                out_valid_reg, out_valid_next;
    ailb_pkg::out_item_t out_data_reg, out_data_next;

    ailb_pkg::div_req_t div_req;
    ailb_pkg::div_rsp_t div_rsp;

    logic        in_take;
    logic        slot_free;
    logic [17:0] tick_sum;
    logic [15:0] half_cyc;

    assign in_stall  = (state_reg != S_IDLE);
    assign in_take   = in_valid && !in_stall;
    assign slot_free = !out_valid_reg || !out_stall;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    assign tick_sum = {1'b0, elapsed_reg} + {8'd0, tick_ms_reg};
    assign half_cyc = {1'b0, breath_cyc_reg[15:1]};

    ailb_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // sequencer and next-state logic
    always_comb
    begin
        state_next     = state_reg;
        led_mode_next  = led_mode_reg;
        elapsed_next   = elapsed_reg;
        phase_next     = phase_reg;
        duty_next      = duty_reg;
        buzzer_next    = buzzer_reg;
        vibration_next = vibration_reg;
        ramp_next      = ramp_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_data_next  = out_data_reg;

        div_req          = '0;
        div_req.steps    = ailb_pkg::MOD_STEPS;
        div_req.dividend = {tick_sum[16:0], 15'd0};
        div_req.divisor  = breath_cyc_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (in_take)
                begin
                    state_next = S_DONE;
                    case (in_data.mode)
                        ailb_pkg::MODE_TICK:
                        begin
                            if (led_mode_reg == ailb_pkg::LED_BREATH)
                            begin
                                if (breath_cyc_reg < 16'd2)
                                begin
                                    elapsed_next = '0;
                                    duty_next    = '0;
                                end
                                else
                                begin
                                    // wrap the phase on the shared divider
                                    div_req.start = 1'b1;
                                    state_next    = S_MOD;
                                end
                            end
                            else if (led_mode_reg == ailb_pkg::LED_FAST)
                            begin
                                if (tick_sum[16:0] >= {1'b0, fast_half_reg})
                                begin
                                    elapsed_next = '0;
                                    phase_next   = !phase_reg;
                                    duty_next    = !phase_reg ? sat_duty(pwm_period_reg) : '0;
                                end
                                else
                                begin
                                    elapsed_next = tick_sum[16:0];
                                end
                            end
                        end
                        ailb_pkg::MODE_ALARM:
                        begin
                            case (in_data.alarm_state)
                                ailb_pkg::AL_IDLE:
                                begin
                                    led_mode_next  = ailb_pkg::LED_BREATH;
                                    elapsed_next   = '0;
                                    phase_next     = 1'b1;
                                    duty_next      = '0;
                                    buzzer_next    = 1'b0;
                                    vibration_next = 1'b0;
                                end
                                ailb_pkg::AL_PENDING,
                                ailb_pkg::AL_CALLING,
                                ailb_pkg::AL_STOPPING:
                                begin
                                    led_mode_next = ailb_pkg::LED_FAST;
                                    elapsed_next  = '0;
                                    phase_next    = 1'b1;
                                    duty_next     = sat_duty(pwm_period_reg);
                                    buzzer_next   = 1'b1;
                                end
                                ailb_pkg::AL_CONNECTED:
                                begin
                                    led_mode_next  = ailb_pkg::LED_SOLID;
                                    elapsed_next   = '0;
                                    duty_next      = sat_duty(pwm_period_reg);
                                    buzzer_next    = 1'b0;
                                    vibration_next = 1'b1;
                                end
                                ailb_pkg::AL_FAILED:
                                begin
                                    led_mode_next  = ailb_pkg::LED_OFF;
                                    elapsed_next   = '0;
                                    duty_next      = '0;
                                    buzzer_next    = 1'b1;
                                    vibration_next = 1'b0;
                                end
                                default:
                                begin
                                    // confirm and the unused code leave all as is
                                    led_mode_next = led_mode_reg;
                                end
                            endcase
                        end
                        ailb_pkg::MODE_LOWBAT:
                        begin
                            buzzer_next = 1'b1;
                        end
                        default:
                        begin
                            led_mode_next = led_mode_reg;
                        end
                    endcase
                end
            end

            S_MOD:
            begin
                // remainder is the new phase; fold it into the triangle ramp
                if (div_rsp.done)
                begin
                    elapsed_next = {1'b0, div_rsp.rem};
                    ramp_next    = (div_rsp.rem < half_cyc) ? div_rsp.rem :
                                   (breath_cyc_reg - div_rsp.rem);
                    state_next   = S_MUL;
                end
            end

            S_MUL:
            begin
                // ramp * period into the divider, divided by the half cycle
                div_req.start    = 1'b1;
                div_req.steps    = ailb_pkg::DIV_STEPS;
                div_req.dividend = 32'(ramp_reg) * 32'(pwm_period_reg);
                div_req.divisor  = half_cyc;
                state_next       = S_DIV;
            end

            S_DIV:
            begin
                if (div_rsp.done)
                begin
                    if (div_rsp.quot > {16'd0, pwm_period_reg})
                    begin
                        duty_next = sat_duty(pwm_period_reg);
                    end
                    else
                    begin
                        duty_next = sat_duty(div_rsp.quot[15:0]);
                    end
                    state_next = S_DONE;
                end
            end

            S_DONE:
            begin
                // hand the result beat to the output register
                if (slot_free)
                begin
                    out_valid_next             = 1'b1;
                    out_data_next.led_duty     = duty_reg;
                    out_data_next.led_mode_now = led_mode_reg;
                    out_data_next.buzzer_on    = buzzer_reg;
                    out_data_next.vibration_on = vibration_reg;
                    state_next                 = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control and LED state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            led_mode_reg  <= ailb_pkg::LED_OFF;
            elapsed_reg   <= '0;
            phase_reg     <= 1'b0;
            duty_reg      <= '0;
            buzzer_reg    <= 1'b0;
            vibration_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            led_mode_reg  <= led_mode_next;
            elapsed_reg   <= elapsed_next;
            phase_reg     <= phase_next;
            duty_reg      <= duty_next;
            buzzer_reg    <= buzzer_next;
            vibration_reg <= vibration_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        ramp_reg     <= ramp_next;
        out_data_reg <= out_data_next;
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_ms_reg    <= ailb_pkg::TICK_MS_RST;
            breath_cyc_reg <= ailb_pkg::BREATH_CYC_RST;
            fast_half_reg  <= ailb_pkg::FAST_HALF_RST;
            pwm_period_reg <= ailb_pkg::PWM_PERIOD_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                ailb_pkg::CFG_TICK_MS:    tick_ms_reg    <= cfg_data[9:0];
                ailb_pkg::CFG_BREATH_CYC: breath_cyc_reg <= cfg_data;
                ailb_pkg::CFG_FAST_HALF:  fast_half_reg  <= cfg_data;
                ailb_pkg::CFG_PWM_PERIOD: pwm_period_reg <= cfg_data;
                default:                  tick_ms_reg    <= tick_ms_reg;
            endcase
        end
    end

endmodule

// ----- hdl/ailb_chk.sv -----
// Port checker for the alarm indicator unit and its bind.
`include "alarm_indicator_led_breath_blink_unit_assert.svh"

module ailb_chk
(
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_stall,
    input logic                out_valid,
    input logic                out_stall,
    input ailb_pkg::out_item_t out_data
);

    // a held result beat keeps its value
    `AILB_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_data))

    // one event at a time: the unit is busy right after taking one
    `AILB_ASSERT_NEXT(a_busy_after_take, clk, rst_n, in_valid && !in_stall, in_stall)

    // LED off always shows zero duty
    `AILB_ASSERT_SAME(a_off_dark, clk, rst_n, out_valid && (out_data.led_mode_now == ailb_pkg::LED_OFF), out_data.led_duty == 16'd0)

endmodule

bind alarm_indicator_led_breath_blink_unit ailb_chk u_ailb_chk
(
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);
